@@ rtl/core/qmin_pkg.sv @@
package qmin_pkg;

   localparam int DATA_W           = 32;
   localparam int DEFAULT_CAPACITY = 256;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_PUSH    = 7'b0000010,
      ST_XFER_RD = 7'b0000100,
      ST_XFER_WR = 7'b0001000,
      ST_POP     = 7'b0010000,
      ST_POP_LD  = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   // operands of the shared min unit, each with its own presence flag
   typedef struct packed {
      data_type a;
      logic     a_ok;
      data_type b;
      logic     b_ok;
   } cmp_req_type;

   function automatic data_type smin(input cmp_req_type req);
      data_type res;
      res = req.a;
      if (!req.a_ok || (req.b_ok && (req.b < req.a))) begin
         res = req.b;
      end
      return res;
   endfunction

endpackage

@@ rtl/core/qmin_mem.sv @@
module qmin_mem #(
   parameter int DEPTH = qmin_pkg::DEFAULT_CAPACITY,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               we,
   input  logic [AW-1:0]      waddr,
   input  qmin_pkg::data_type wdata,
   input  logic [AW-1:0]      raddr,
   output qmin_pkg::data_type rdata
);

   qmin_pkg::data_type mem [DEPTH];
   qmin_pkg::data_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/qmin_ctrl.sv @@
module qmin_ctrl #(
   parameter int CAPACITY = qmin_pkg::DEFAULT_CAPACITY,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  qmin_pkg::data_type req_value,
   output logic               rsp_strobe,
   output qmin_pkg::data_type rsp_minimum,
   output logic               rsp_has_minimum,
   output logic [CW-1:0]      rsp_entry_count,
   output logic               rsp_rejected,
   // input stack memory (values only)
   output logic               in_we,
   output logic [AW-1:0]      in_waddr,
   output qmin_pkg::data_type in_wdata,
   output logic [AW-1:0]      in_raddr,
   input  qmin_pkg::data_type in_rdata,
   // output stack memory (running minima only)
   output logic               out_we,
   output logic [AW-1:0]      out_waddr,
   output qmin_pkg::data_type out_wdata,
   output logic [AW-1:0]      out_raddr,
   input  qmin_pkg::data_type out_rdata
);

   localparam logic [CW-1:0] CAP = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE = CW'(1);
   localparam logic [CW-1:0] TWO = CW'(2);

   qmin_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       in_depth_ff, in_depth_in;
   logic [CW-1:0]       out_depth_ff, out_depth_in;
   qmin_pkg::data_type  in_min_ff, in_min_in;
   qmin_pkg::data_type  out_min_ff, out_min_in;
   qmin_pkg::data_type  value_ff, value_in;
   logic                rejected_ff, rejected_in;
   logic                strobe_ff, strobe_in;
   qmin_pkg::data_type  minimum_ff, minimum_in;
   logic                has_ff, has_in;
   logic [CW-1:0]       count_ff, count_in;
   qmin_pkg::cmp_req_type cmp_req;
   qmin_pkg::data_type  cmp_res;
   logic [CW-1:0]       total;

   assign total   = in_depth_ff + out_depth_ff;
   assign cmp_res = qmin_pkg::smin(cmp_req);

   // shared min unit operand selection
   always_comb begin
      cmp_req = '{a: in_min_ff, a_ok: (in_depth_ff != '0),
                  b: out_min_ff, b_ok: (out_depth_ff != '0)};
      case (state_ff)
         qmin_pkg::ST_PUSH: begin
            cmp_req = '{a: value_ff, a_ok: 1'b1,
                        b: in_min_ff, b_ok: (in_depth_ff != '0)};
         end
         qmin_pkg::ST_XFER_WR: begin
            cmp_req = '{a: in_rdata, a_ok: 1'b1,
                        b: out_min_ff, b_ok: (out_depth_ff != '0)};
         end
         default: begin
         end
      endcase
   end

   assign in_raddr  = AW'(in_depth_ff - ONE);
   assign out_raddr = AW'(out_depth_ff - TWO);
   assign in_waddr  = AW'(in_depth_ff);
   assign in_wdata  = value_ff;
   assign out_waddr = AW'(out_depth_ff);
   assign out_wdata = cmp_res;

   always_comb begin
      state_in     = state_ff;
      in_depth_in  = in_depth_ff;
      out_depth_in = out_depth_ff;
      in_min_in    = in_min_ff;
      out_min_in   = out_min_ff;
      value_in     = value_ff;
      rejected_in  = rejected_ff;
      strobe_in    = 1'b0;
      minimum_in   = minimum_ff;
      has_in       = has_ff;
      count_in     = count_ff;
      in_we        = 1'b0;
      out_we       = 1'b0;
      case (state_ff)
         qmin_pkg::ST_IDLE: begin
            if (start) begin
               value_in    = req_value;
               rejected_in = 1'b0;
               if (qmin_pkg::op_type'(req_operation) == qmin_pkg::OP_PUSH) begin
                  if (total == CAP) begin
                     rejected_in = 1'b1;
                     state_in    = qmin_pkg::ST_DONE;
                  end else begin
                     state_in = qmin_pkg::ST_PUSH;
                  end
               end else if (out_depth_ff != '0) begin
                  state_in = qmin_pkg::ST_POP;
               end else if (in_depth_ff != '0) begin
                  state_in = qmin_pkg::ST_XFER_RD;
               end else begin
                  state_in = qmin_pkg::ST_DONE;
               end
            end
         end
         qmin_pkg::ST_PUSH: begin
            in_we       = 1'b1;
            in_min_in   = cmp_res;
            in_depth_in = in_depth_ff + ONE;
            state_in    = qmin_pkg::ST_DONE;
         end
         qmin_pkg::ST_XFER_RD: begin
            in_depth_in = in_depth_ff - ONE;
            state_in    = qmin_pkg::ST_XFER_WR;
         end
         qmin_pkg::ST_XFER_WR: begin
            out_we       = 1'b1;
            out_min_in   = cmp_res;
            out_depth_in = out_depth_ff + ONE;
            state_in     = (in_depth_ff == '0) ? qmin_pkg::ST_POP : qmin_pkg::ST_XFER_RD;
         end
         qmin_pkg::ST_POP: begin
            // read of the entry below the top goes out this cycle
            out_depth_in = out_depth_ff - ONE;
            state_in     = (out_depth_ff >= TWO) ? qmin_pkg::ST_POP_LD : qmin_pkg::ST_DONE;
         end
         qmin_pkg::ST_POP_LD: begin
            out_min_in = out_rdata;
            state_in   = qmin_pkg::ST_DONE;
         end
         qmin_pkg::ST_DONE: begin
            has_in     = (in_depth_ff != '0) || (out_depth_ff != '0);
            minimum_in = has_in ? cmp_res : '0;
            count_in   = total;
            strobe_in  = 1'b1;
            state_in   = qmin_pkg::ST_IDLE;
         end
         default: begin
            state_in = qmin_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qmin_pkg::ST_IDLE;
         in_depth_ff  <= '0;
         out_depth_ff <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_depth_ff  <= in_depth_in;
         out_depth_ff <= out_depth_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      in_min_ff   <= in_min_in;
      out_min_ff  <= out_min_in;
      value_ff    <= value_in;
      rejected_ff <= rejected_in;
      minimum_ff  <= minimum_in;
      has_ff      <= has_in;
      count_ff    <= count_in;
   end

   assign busy            = (state_ff != qmin_pkg::ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_minimum     = minimum_ff;
   assign rsp_has_minimum = has_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_rejected    = rejected_ff;

endmodule

@@ rtl/core/queue_with_running_minimum_top.sv @@
// from an accepted start the sequencer runs to ST_DONE, which registers rsp_strobe: a push
// passes ST_PUSH; a rejected push or a pop of an empty queue goes straight to ST_DONE; a pop
// passes ST_POP, then ST_POP_LD unless it empties the output stack, and one that finds the
// output stack empty first moves each input stack value by ST_XFER_RD and ST_XFER_WR
// start is taken again in the rsp_strobe cycle, not before; each value is moved once
// reset clears both stack depths and the sequencer; stack memories are not cleared
module queue_with_running_minimum_top #(
   parameter int CAPACITY = qmin_pkg::DEFAULT_CAPACITY,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_minimum,
   output logic               rsp_has_minimum,
   output logic [CW-1:0]      rsp_entry_count,
   output logic               rsp_rejected
);

   logic               in_we, out_we;
   logic [AW-1:0]      in_waddr, in_raddr, out_waddr, out_raddr;
   qmin_pkg::data_type in_wdata, in_rdata, out_wdata, out_rdata;

   qmin_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_minimum     (rsp_minimum),
      .rsp_has_minimum (rsp_has_minimum),
      .rsp_entry_count (rsp_entry_count),
      .rsp_rejected    (rsp_rejected),
      .in_we           (in_we),
      .in_waddr        (in_waddr),
      .in_wdata        (in_wdata),
      .in_raddr        (in_raddr),
      .in_rdata        (in_rdata),
      .out_we          (out_we),
      .out_waddr       (out_waddr),
      .out_wdata       (out_wdata),
      .out_raddr       (out_raddr),
      .out_rdata       (out_rdata)
   );

   qmin_mem #(.DEPTH(CAPACITY), .AW(AW)) u_in_mem (
      .clock (clock),
      .we    (in_we),
      .waddr (in_waddr),
      .wdata (in_wdata),
      .raddr (in_raddr),
      .rdata (in_rdata)
   );

   qmin_mem #(.DEPTH(CAPACITY), .AW(AW)) u_out_mem (
      .clock (clock),
      .we    (out_we),
      .waddr (out_waddr),
      .wdata (out_wdata),
      .raddr (out_raddr),
      .rdata (out_rdata)
   );

endmodule

@@ rtl/core/qmin_chk.sv @@
module qmin_chk #(
   parameter int CW = 9
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic signed [31:0] rsp_minimum,
   input logic               rsp_has_minimum,
   input logic [CW-1:0]      rsp_entry_count,
   input logic               rsp_rejected
);

   // a result is only shown once the sequencer is back to accepting
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer accepted without going busy");

   a_has_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_has_minimum == (rsp_entry_count != '0)))
      else $error("minimum flag disagrees with count");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_has_minimum) |-> (rsp_minimum == '0))
      else $error("empty queue reports a nonzero minimum");

   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_rejected) |-> rsp_has_minimum)
      else $error("rejected push on a queue that is not full");

endmodule

bind queue_with_running_minimum_top qmin_chk #(.CW(CW)) u_qmin_chk (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_minimum     (rsp_minimum),
   .rsp_has_minimum (rsp_has_minimum),
   .rsp_entry_count (rsp_entry_count),
   .rsp_rejected    (rsp_rejected)
);
